FILE: sv/dust_sensor_average_and_scale_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the dust sensor core; empty under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef DUST_SENSOR_AVERAGE_AND_SCALE_CORE_ASSERT_SVH
`define DUST_SENSOR_AVERAGE_AND_SCALE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define DSAS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dsas assertion failed");
// checked at every edge, reset included
`define DSAS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("dsas assertion failed");
`else
`define DSAS_ASSERT(name, clk, rst_n, prop)
`define DSAS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: sv/dsas_pkg.sv
// ----------------------------------------------------------------------------
// dsas_pkg
// Shared widths, constants and types of the dust sensor average/scale core.
// ----------------------------------------------------------------------------
package dsas_pkg;

  localparam int WINDOW   = 10;
  localparam int ADC_BITS = 12;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int VOLT_W   = 17;
  localparam int DENS_W   = 25;
  localparam int ZERO_W   = 16;
  localparam int SENS_W   = 16;
  localparam int VREF_W   = 13;
  localparam int RATIO_W  = 5;

  localparam int RING_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // sum / WINDOW as multiply by floor reciprocal plus one correction step
  localparam int DIV_SHIFT   = 20;
  localparam int DIV_RECIP_W = DIV_SHIFT + 1;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'((1 << DIV_SHIFT) / WINDOW);

  // avg * vref >> ADC_BITS, then * ratio
  localparam int PROD_W  = SUM_W + VREF_W - ADC_BITS;
  localparam int SCALE_W = PROD_W + RATIO_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [ZERO_W-1:0]  ZERO_RST  = ZERO_W'(400);
  localparam logic [SENS_W-1:0]  SENS_RST  = SENS_W'(13107);
  localparam logic [VREF_W-1:0]  VREF_RST  = VREF_W'(3300);
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(11);

  typedef enum logic [1:0] {
    REG_ZERO_DUST = 2'd0,
    REG_SENS      = 2'd1,
    REG_VREF      = 2'd2,
    REG_RATIO     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ZERO_W-1:0]  zero_dust_mv;
    logic [SENS_W-1:0]  sensitivity_q16;
    logic [VREF_W-1:0]  vref_mv;
    logic [RATIO_W-1:0] vdiv_ratio;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div;
    logic corr;
    logic volt;
    logic scale;
    logic dens;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

FILE: sv/dsas_regs.sv
// ----------------------------------------------------------------------------
// dsas_regs
// APB configuration registers: zero offset, sensitivity, vref, divider ratio.
// ----------------------------------------------------------------------------
module dsas_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsas_pkg::APB_AW-1:0] paddr,
  input  logic [dsas_pkg::APB_DW-1:0] pwdata,
  output logic [dsas_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output dsas_pkg::cfg_t              cfg_o
);

  dsas_pkg::cfg_t     cfg_q;
  dsas_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = dsas_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_dust_mv    <= dsas_pkg::ZERO_RST;
      cfg_q.sensitivity_q16 <= dsas_pkg::SENS_RST;
      cfg_q.vref_mv         <= dsas_pkg::VREF_RST;
      cfg_q.vdiv_ratio      <= dsas_pkg::RATIO_RST;
    end else if (wr_en) begin
      unique case (idx)
        dsas_pkg::REG_ZERO_DUST: cfg_q.zero_dust_mv    <= pwdata[dsas_pkg::ZERO_W-1:0];
        dsas_pkg::REG_SENS:      cfg_q.sensitivity_q16 <= pwdata[dsas_pkg::SENS_W-1:0];
        dsas_pkg::REG_VREF:      cfg_q.vref_mv         <= pwdata[dsas_pkg::VREF_W-1:0];
        dsas_pkg::REG_RATIO:     cfg_q.vdiv_ratio      <= pwdata[dsas_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dsas_pkg::REG_ZERO_DUST: prdata = dsas_pkg::APB_DW'(cfg_q.zero_dust_mv);
      dsas_pkg::REG_SENS:      prdata = dsas_pkg::APB_DW'(cfg_q.sensitivity_q16);
      dsas_pkg::REG_VREF:      prdata = dsas_pkg::APB_DW'(cfg_q.vref_mv);
      dsas_pkg::REG_RATIO:     prdata = dsas_pkg::APB_DW'(cfg_q.vdiv_ratio);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: sv/dsas_ctrl.sv
// ----------------------------------------------------------------------------
// dsas_ctrl
// Sequencer: steps one request through divide, voltage and density stages.
// ----------------------------------------------------------------------------
module dsas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dsas_pkg::status_t status_i,
  output dsas_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_CORR  = 6'b000100,
    ST_VOLT  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_DENS  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = ST_VOLT;
      end
      ST_VOLT: begin
        cmd_o.volt = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DENS;
      end
      ST_DENS: begin
        // hold until the output register can take the result
        if (!status_i.out_busy) begin
          cmd_o.dens = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/dsas_dp.sv
// ----------------------------------------------------------------------------
// dsas_dp
// Datapath: sample ring, running sum, average, voltage and density stages.
// ----------------------------------------------------------------------------
module dsas_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dsas_pkg::cmd_t                cmd_i,
  output dsas_pkg::status_t             status_o,
  input  dsas_pkg::cfg_t                cfg_i,
  input  logic [dsas_pkg::SAMPLE_W-1:0] adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dsas_pkg::SAMPLE_W-1:0] raw_sample_o,
  output logic [dsas_pkg::VOLT_W-1:0]   voltage_mv_o,
  output logic [dsas_pkg::DENS_W-1:0]   density_q8_o
);

  localparam int DIV_PROD_W  = dsas_pkg::SUM_W + dsas_pkg::DIV_RECIP_W;
  localparam int VPROD_W     = dsas_pkg::SUM_W + dsas_pkg::VREF_W;
  localparam int DPROD_W     = dsas_pkg::VOLT_W + dsas_pkg::SENS_W;

  logic [dsas_pkg::SAMPLE_W-1:0]   ring_q [dsas_pkg::WINDOW];
  logic [dsas_pkg::RING_IDX_W-1:0] idx_q;
  logic                            primed_q;
  logic [dsas_pkg::SUM_W-1:0]      sum_q;
  logic [dsas_pkg::SAMPLE_W-1:0]   raw_q;
  logic [dsas_pkg::SUM_W-1:0]      quot_q;
  logic [dsas_pkg::SUM_W-1:0]      avg_q;
  logic [dsas_pkg::PROD_W-1:0]     vprod_q;
  logic [dsas_pkg::VOLT_W-1:0]     volt_q;

  logic                            out_valid_q;
  logic [dsas_pkg::SAMPLE_W-1:0]   out_raw_q;
  logic [dsas_pkg::VOLT_W-1:0]     out_volt_q;
  logic [dsas_pkg::DENS_W-1:0]     out_dens_q;

  logic [DIV_PROD_W-1:0]           div_prod;
  logic [dsas_pkg::SUM_W-1:0]      quot_times_w;
  logic [dsas_pkg::SUM_W-1:0]      rem;
  logic [VPROD_W-1:0]              vprod_full;
  logic [dsas_pkg::SCALE_W-1:0]    scaled;
  logic [dsas_pkg::VOLT_W-1:0]     diff;
  logic [DPROD_W-1:0]              dprod;
  logic [dsas_pkg::DENS_W-1:0]     dens;

  assign div_prod     = DIV_PROD_W'(sum_q) * DIV_PROD_W'(dsas_pkg::DIV_RECIP);
  assign quot_times_w = dsas_pkg::SUM_W'(quot_q * dsas_pkg::WINDOW);
  assign rem          = sum_q - quot_times_w;
  assign vprod_full   = VPROD_W'(avg_q) * VPROD_W'(cfg_i.vref_mv);
  assign scaled       = dsas_pkg::SCALE_W'(vprod_q) * dsas_pkg::SCALE_W'(cfg_i.vdiv_ratio);
  assign diff         = (volt_q > dsas_pkg::VOLT_W'(cfg_i.zero_dust_mv)) ?
                        volt_q - dsas_pkg::VOLT_W'(cfg_i.zero_dust_mv) : '0;
  assign dprod        = DPROD_W'(diff) * DPROD_W'(cfg_i.sensitivity_q16);
  assign dens         = dprod[DPROD_W-1:8];

  // ring and running sum; the first sample after reset fills every entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (!primed_q) begin
        for (int i = 0; i < dsas_pkg::WINDOW; i++) begin
          ring_q[i] <= adc_sample_i;
        end
      end else begin
        ring_q[idx_q] <= adc_sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      primed_q <= 1'b0;
      sum_q    <= '0;
    end else if (cmd_i.load) begin
      primed_q <= 1'b1;
      if (!primed_q) begin
        idx_q <= '0;
        sum_q <= dsas_pkg::SUM_W'(adc_sample_i * dsas_pkg::WINDOW);
      end else begin
        sum_q <= sum_q - dsas_pkg::SUM_W'(ring_q[idx_q]) + dsas_pkg::SUM_W'(adc_sample_i);
        idx_q <= (idx_q == dsas_pkg::RING_IDX_W'(dsas_pkg::WINDOW - 1)) ? '0 :
                 idx_q + dsas_pkg::RING_IDX_W'(1);
      end
    end
  end

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= adc_sample_i;
    end
    if (cmd_i.div) begin
      quot_q <= div_prod[dsas_pkg::DIV_SHIFT +: dsas_pkg::SUM_W];
    end
    if (cmd_i.corr) begin
      // estimate is low by at most one
      avg_q <= quot_q + dsas_pkg::SUM_W'(rem >= dsas_pkg::SUM_W'(dsas_pkg::WINDOW));
    end
    if (cmd_i.volt) begin
      vprod_q <= vprod_full[VPROD_W-1:dsas_pkg::ADC_BITS];
    end
    if (cmd_i.scale) begin
      volt_q <= (|scaled[dsas_pkg::SCALE_W-1:dsas_pkg::VOLT_W]) ? '1 :
                scaled[dsas_pkg::VOLT_W-1:0];
    end
    if (cmd_i.dens) begin
      out_raw_q  <= raw_q;
      out_volt_q <= volt_q;
      out_dens_q <= dens;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.dens) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign raw_sample_o      = out_raw_q;
  assign voltage_mv_o      = out_volt_q;
  assign density_q8_o      = out_dens_q;

endmodule

FILE: sv/dust_sensor_average_and_scale_core.sv
// ----------------------------------------------------------------------------
// dust_sensor_average_and_scale_core
// Moving average of ADC samples with conversion to millivolts and dust density.
// ----------------------------------------------------------------------------
// One request at a time: a sample is taken when in_stall_o is low, and its
// result (raw sample, averaged voltage in mV, density in 1/256 units) shows
// up in the output register. The sequencer walks ring update,
// reciprocal divide, divide correction, vref multiply, ratio multiply and
// density multiply, one register stage each, and takes no new sample before
// the last step; that step waits while a previous result is still stalled.
// Registers are set over APB: 0x0 zero-dust mV, 0x4 sensitivity Q0.16,
// 0x8 vref mV, 0xC divider ratio. Voltage saturates at 17 bits.
// ----------------------------------------------------------------------------
`include "dust_sensor_average_and_scale_core_assert.svh"

module dust_sensor_average_and_scale_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsas_pkg::APB_AW-1:0]   paddr,
  input  logic [dsas_pkg::APB_DW-1:0]   pwdata,
  output logic [dsas_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dsas_pkg::SAMPLE_W-1:0] adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dsas_pkg::SAMPLE_W-1:0] raw_sample_o,
  output logic [dsas_pkg::VOLT_W-1:0]   voltage_mv_o,
  output logic [dsas_pkg::DENS_W-1:0]   density_q8_o
);

  dsas_pkg::cfg_t    cfg;
  dsas_pkg::cmd_t    cmd;
  dsas_pkg::status_t status;

  dsas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsas_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .raw_sample_o (raw_sample_o),
    .voltage_mv_o (voltage_mv_o),
    .density_q8_o (density_q8_o)
  );

  // a taken request keeps the input closed while it is processed
  `DSAS_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a new result only appears at the end of a request in flight
  `DSAS_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  // exactly one sequencer command per cycle at most
  `DSAS_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0(cmd))
  `DSAS_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |-> !out_valid_o)

endmodule

FILE: dv/tb_dust_sensor_average_and_scale_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dust_sensor_average_and_scale_core
// Drives ADC samples and APB register writes into the dust sensor core and
// checks every reading (raw sample, averaged mV, density) against an
// in-bench predictor of the moving average and the scaling chain.
// ----------------------------------------------------------------------------

localparam longint unsigned VOLT_CAP = (64'd1 << dsas_pkg::VOLT_W) - 1;
localparam longint unsigned DENS_CAP = (64'd1 << dsas_pkg::DENS_W) - 1;

typedef struct packed {
  logic [dsas_pkg::SAMPLE_W-1:0] raw;
  logic [dsas_pkg::VOLT_W-1:0]   volt;
  logic [dsas_pkg::DENS_W-1:0]   dens;
} reading_t;

class dust_reading_predictor;
  dsas_pkg::cfg_t                regs;
  logic [dsas_pkg::SAMPLE_W-1:0] ring [dsas_pkg::WINDOW];
  logic [dsas_pkg::SUM_W-1:0]    sum;
  int unsigned                   slot;
  bit                            primed;
  reading_t                      pending_readings [$];
  int unsigned                   errors;

  function new();
    regs.zero_dust_mv    = dsas_pkg::ZERO_RST;
    regs.sensitivity_q16 = dsas_pkg::SENS_RST;
    regs.vref_mv         = dsas_pkg::VREF_RST;
    regs.vdiv_ratio      = dsas_pkg::RATIO_RST;
    sum    = '0;
    slot   = 0;
    primed = 1'b0;
    errors = 0;
  endfunction

  function void set_reg(dsas_pkg::reg_idx_e idx, logic [dsas_pkg::APB_DW-1:0] value);
    case (idx)
      dsas_pkg::REG_ZERO_DUST: regs.zero_dust_mv    = value[dsas_pkg::ZERO_W-1:0];
      dsas_pkg::REG_SENS:      regs.sensitivity_q16 = value[dsas_pkg::SENS_W-1:0];
      dsas_pkg::REG_VREF:      regs.vref_mv         = value[dsas_pkg::VREF_W-1:0];
      dsas_pkg::REG_RATIO:     regs.vdiv_ratio      = value[dsas_pkg::RATIO_W-1:0];
      default: ;
    endcase
  endfunction

  // sample request accepted: update the window and queue the reading
  function void take_sample(logic [dsas_pkg::SAMPLE_W-1:0] s);
    longint unsigned avg;
    longint unsigned volt;
    longint unsigned dens;
    reading_t        r;
    if (!primed) begin
      // first sample after reset stands for the whole window
      foreach (ring[i]) ring[i] = s;
      sum    = dsas_pkg::SUM_W'(s * dsas_pkg::WINDOW);
      slot   = 0;
      primed = 1'b1;
    end else begin
      sum        = sum - dsas_pkg::SUM_W'(ring[slot]) + dsas_pkg::SUM_W'(s);
      ring[slot] = s;
      slot       = (slot + 1) % dsas_pkg::WINDOW;
    end
    avg  = sum / dsas_pkg::WINDOW;
    volt = ((avg * regs.vref_mv) >> dsas_pkg::ADC_BITS) * regs.vdiv_ratio;
    if (volt > VOLT_CAP) volt = VOLT_CAP;
    dens = 0;
    if (volt > regs.zero_dust_mv)
      dens = ((volt - regs.zero_dust_mv) * regs.sensitivity_q16) >> 8;
    if (dens > DENS_CAP) dens = DENS_CAP;
    r.raw  = s;
    r.volt = dsas_pkg::VOLT_W'(volt);
    r.dens = dsas_pkg::DENS_W'(dens);
    pending_readings.push_back(r);
  endfunction

  function void match_reading(logic [dsas_pkg::SAMPLE_W-1:0] raw,
                              logic [dsas_pkg::VOLT_W-1:0] volt,
                              logic [dsas_pkg::DENS_W-1:0] dens);
    reading_t e;
    if (pending_readings.size() == 0) begin
      $error("unexpected reading: raw_sample %0d voltage_mv %0d density_q8 %0d",
             raw, volt, dens);
      errors++;
      return;
    end
    e = pending_readings.pop_front();
    if (raw !== e.raw) begin
      $error("raw_sample: expected %0d, actual %0d", e.raw, raw);
      errors++;
    end
    if (volt !== e.volt) begin
      $error("voltage_mv: expected %0d, actual %0d", e.volt, volt);
      errors++;
    end
    if (dens !== e.dens) begin
      $error("density_q8: expected %0d, actual %0d", e.dens, dens);
      errors++;
    end
  endfunction
endclass

module tb_dust_sensor_average_and_scale_core;

  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 192;
  localparam int          HOLD_AT       = 500;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic [dsas_pkg::SAMPLE_W-1:0] OPENING [18] = '{
    12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
    12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h001, 12'h800, 12'h7FF,
    12'h555, 12'hAAA
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dsas_pkg::APB_AW-1:0]   paddr;
  logic [dsas_pkg::APB_DW-1:0]   pwdata;
  logic [dsas_pkg::APB_DW-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [dsas_pkg::SAMPLE_W-1:0] adc_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [dsas_pkg::SAMPLE_W-1:0] raw_sample_o;
  logic [dsas_pkg::VOLT_W-1:0]   voltage_mv_o;
  logic [dsas_pkg::DENS_W-1:0]   density_q8_o;

  dust_reading_predictor pred;

  bit          send_burst;
  bit          recv_burst;
  int          level;
  int unsigned stall_left;
  int unsigned readings_taken;
  int unsigned cycle_count;

  dust_sensor_average_and_scale_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .raw_sample_o (raw_sample_o),
    .voltage_mv_o (voltage_mv_o),
    .density_q8_o (density_q8_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dust_sensor_average_and_scale_core test failed");
      $finish;
    end
  end

  // result side: check, then draw the stall before the next reading
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pred.match_reading(raw_sample_o, voltage_mv_o, density_q8_o);
      readings_taken++;
      if (readings_taken % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (readings_taken == HOLD_AT) stall_left = HOLD_CYCLES;
      else stall_left = recv_burst ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // all tasks start and end at a falling edge
  task automatic write_reg(input dsas_pkg::reg_idx_e idx,
                           input logic [dsas_pkg::APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = dsas_pkg::APB_AW'(idx) << 2;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    pred.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // field value in the low bits, junk above it
  function automatic logic [dsas_pkg::APB_DW-1:0] pad(int unsigned value, int w);
    return (dsas_pkg::APB_DW'($urandom()) << w) |
           dsas_pkg::APB_DW'(value & ((32'd1 << w) - 1));
  endfunction

  task automatic program_regs(input int unsigned zero, input int unsigned sens,
                              input int unsigned vref, input int unsigned ratio);
    write_reg(dsas_pkg::REG_ZERO_DUST, pad(zero, dsas_pkg::ZERO_W));
    write_reg(dsas_pkg::REG_SENS, pad(sens, dsas_pkg::SENS_W));
    write_reg(dsas_pkg::REG_VREF, pad(vref, dsas_pkg::VREF_W));
    write_reg(dsas_pkg::REG_RATIO, pad(ratio, dsas_pkg::RATIO_W));
  endtask

  task automatic offer_sample(input logic [dsas_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    adc_sample_i = s;
    do @(posedge clk_i); while (in_stall_o);
    pred.take_sample(s);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pred.pending_readings.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly a slowly drifting level, with jumps, rails and uniform noise
  function automatic logic [dsas_pkg::SAMPLE_W-1:0] next_sample();
    int step;
    case ($urandom_range(0, 9)) inside
      8: return $urandom_range(0, 1) ? {dsas_pkg::SAMPLE_W{1'b1}} :
                                       {dsas_pkg::SAMPLE_W{1'b0}};
      6, 7, 9: return dsas_pkg::SAMPLE_W'($urandom());
      default: begin
        step  = int'($urandom_range(0, 128)) - 64;
        level = level + step;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        return dsas_pkg::SAMPLE_W'(level);
      end
    endcase
  endfunction

  initial begin
    pred           = new();
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    adc_sample_i   = '0;
    send_burst     = 1'b0;
    recv_burst     = 1'b0;
    level          = 2048;
    stall_left     = 0;
    readings_taken = 0;
    cycle_count    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings; the first sample fills the window
    foreach (OPENING[i]) offer_sample(OPENING[i]);
    drain();
    // voltage saturates, density near its top
    program_regs(0, 65535, 8191, 31);
    repeat (4) offer_sample(12'hFFF);
    drain();
    // zero products, offset above any voltage
    program_regs(65535, 0, 0, 0);
    offer_sample(12'hABC);
    offer_sample(12'h543);
    drain();
    program_regs(0, 1, 1, 1);
    offer_sample(12'hFFF);
    offer_sample(12'h000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ((p == 0) ? 0 : $urandom_range(0, 3))
        0: program_regs($urandom_range(0, 4000), $urandom_range(0, 65535),
                        $urandom_range(1, 5000), $urandom_range(1, 16));
        1: program_regs($urandom(), $urandom(), $urandom(), $urandom());
        2: program_regs(dsas_pkg::ZERO_RST, dsas_pkg::SENS_RST,
                        dsas_pkg::VREF_RST, dsas_pkg::RATIO_RST);
        default: program_regs($urandom_range(0, 1) ? 65535 : 0,
                              $urandom_range(0, 1) ? 65535 : 0,
                              $urandom_range(0, 1) ? 8191 : 1,
                              $urandom_range(0, 1) ? 31 : 1);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
        offer_sample(next_sample());
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (pred.errors == 0) begin
      $display("dust_sensor_average_and_scale_core test passed");
    end else begin
      $display("dust_sensor_average_and_scale_core test failed");
    end
    $finish;
  end

endmodule
